// ===== rtl/swcr_pkg.sv =====
// shared types, codes and helpers for the sector wall column rasterizer
// no dependencies; imported by every rtl file of the block but swcr_ram
package swcr_pkg;

    // default sizes of the line store and the fixed point format
    localparam int DEF_COLUMNS   = 256;
    localparam int DEF_SECTORS   = 4;
    localparam int DEF_FRAC_BITS = 8;

    // surface modes carried in tuser
    localparam logic [2:0] KIND_NONE         = 3'd0;
    localparam logic [2:0] KIND_STORE_BOTTOM = 3'd1;
    localparam logic [2:0] KIND_STORE_TOP    = 3'd2;
    localparam logic [2:0] KIND_FILL_BOTTOM  = 3'd3;
    localparam logic [2:0] KIND_FILL_TOP     = 3'd4;

    // register select bit of the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // register reset values
    localparam logic [8:0] WIDTH_RESET  = 9'd160;
    localparam logic [8:0] HEIGHT_RESET = 9'd120;

    // payload packing
    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 56;

    // one vertical span on its way to the output
    typedef struct packed {
        logic        valid;
        logic [7:0]  column;
        logic [7:0]  start;
        logic [7:0]  stop;
        logic [31:0] color;
    } span_t;

    // screen dimension saturated to [2, 256]
    function automatic logic [8:0] sat_dim(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v < 9'd2)
        begin
            r = 9'd2;
        end
        else if (v > 9'd256)
        begin
            r = 9'd256;
        end
        return r;
    endfunction

endpackage

// ===== rtl/swcr_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies; used for the per-sector surface line store
module swcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swcr_div.sv =====
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on swcr_pkg; an oversized quotient is reported through the overflow flag
module swcr_div #(
    parameter int PMW = 51,
    parameter int AW  = 26,
    parameter int QW  = 25
) (
    input  logic           clk,
    input  logic [QW:0]    en,
    input  logic [PMW-1:0] num,
    input  logic [AW-1:0]  den,
    input  logic           neg,
    output logic [QW-1:0]  quot,
    output logic           ovf,
    output logic           neg_out
);

    import swcr_pkg::*;

    localparam int CMPW = ((PMW > AW + QW) ? PMW : AW + QW) + 1;

    logic [CMPW-1:0] rem_reg [QW+1];
    logic [AW-1:0]   den_reg [QW+1];
    logic [QW-1:0]   quot_reg [QW+1];
    logic [QW:0]     ovf_reg;
    logic [QW:0]     neg_reg;

    // entry stage: overflow when the quotient needs more than QW bits
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= CMPW'(num);
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= CMPW'(num) >= (CMPW'(den) << QW);
            neg_reg[0]  <= neg;
        end
    end

    // one trial subtraction per stage, msb first
    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        localparam int SH = QW - j;
        logic [CMPW-1:0] shifted;
        logic            ge;

        assign shifted = CMPW'(den_reg[j-1]) << SH;
        assign ge      = rem_reg[j-1] >= shifted;

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= ge ? rem_reg[j-1] - shifted : rem_reg[j-1];
                den_reg[j]  <= den_reg[j-1];
                quot_reg[j] <= quot_reg[j-1] | (QW'(ge) << SH);
                ovf_reg[j]  <= ovf_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
            end
        end
    end

    assign quot    = quot_reg[QW];
    assign ovf     = ovf_reg[QW];
    assign neg_out = neg_reg[QW];

endmodule

// ===== rtl/swcr_span.sv =====
// span builder: fill span from the stored line, then the wall span
// depends on swcr_pkg for kind codes and span_t
module swcr_span #(
    parameter int FRAC_BITS = 8
) (
    input  logic [2:0]            kind,
    input  logic                  live,
    input  logic [7:0]            line,
    input  logic [FRAC_BITS+7:0]  yb,
    input  logic [FRAC_BITS+7:0]  yt,
    input  logic [7:0]            column,
    input  logic [31:0]           wall_color,
    input  logic [31:0]           fill_color,
    output swcr_pkg::span_t       slot_a,
    output swcr_pkg::span_t       slot_b
);

    import swcr_pkg::*;

    localparam int CW = FRAC_BITS + 8;

    logic [CW:0]  yb_up;
    logic [CW:0]  yt_up;
    logic [7:0]   yb_floor;
    logic [7:0]   yb_ceil;
    logic [7:0]   yt_floor;
    logic [7:0]   yt_ceil;
    span_t        fill;
    span_t        wall;

    // floor and ceiling rows of both edges
    assign yb_up    = (CW+1)'(yb) + (CW+1)'((1 << FRAC_BITS) - 1);
    assign yt_up    = (CW+1)'(yt) + (CW+1)'((1 << FRAC_BITS) - 1);
    assign yb_floor = yb[FRAC_BITS +: 8];
    assign yt_floor = yt[FRAC_BITS +: 8];
    assign yb_ceil  = yb_up[FRAC_BITS +: 8];
    assign yt_ceil  = yt_up[FRAC_BITS +: 8];

    // fill span by mode
    always_comb
    begin
        fill.column = column;
        fill.color  = fill_color;
        fill.start  = line;
        fill.stop   = yb_ceil;
        fill.valid  = 1'b0;
        case (kind)
            KIND_FILL_BOTTOM:
            begin
                fill.start = line;
                fill.stop  = yb_ceil;
                fill.valid = live && (yb_ceil > line);
            end
            KIND_FILL_TOP:
            begin
                fill.start = yt_floor;
                fill.stop  = line;
                fill.valid = live && (line > yt_floor);
            end
            default:
            begin
                fill.valid = 1'b0;
            end
        endcase
    end

    // wall span between the edges
    always_comb
    begin
        wall.column = column;
        wall.color  = wall_color;
        wall.start  = yb_floor;
        wall.stop   = yt_ceil;
        wall.valid  = live && (yt_ceil > yb_floor);
    end

    // compact into emission order
    always_comb
    begin
        if (fill.valid)
        begin
            slot_a = fill;
            slot_b = wall;
        end
        else
        begin
            slot_a = wall;
            slot_b = wall;
            slot_b.valid = 1'b0;
        end
    end

endmodule

// ===== rtl/sector_wall_column_raster.sv =====
// top level of the sector wall column rasterizer: ports, pipeline, line store
// depends on swcr_pkg, swcr_ram, swcr_div and swcr_span
//
//  channel   direction  handshake                 contents
//  s_*       in         s_tvalid / s_tready       one wall column
//  m_*       out        m_tvalid / m_tready       one vertical span
//  apb       in         psel, penable, pready     screen width and height
//
// the divider retires one quotient bit per stage (QW = 25 bits at the defaults);
// one column enters each cycle while the line store is not clearing and the output is not stalled.
// a column giving two spans holds the output register until both are sent.
// after reset a clearing pass writes zeros over all SECTORS*COLUMNS entries of
// the line store (1024 at the defaults) with s_tready low.
// a stall on m_tready fills pipeline bubbles before backing up to s_tready.
module sector_wall_column_raster #(
    parameter int COLUMNS   = swcr_pkg::DEF_COLUMNS,
    parameter int SECTORS   = swcr_pkg::DEF_SECTORS,
    parameter int FRAC_BITS = swcr_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // fields from bit 0: sector, column, x_left, x_right, y_left_bottom,
    // y_right_bottom, y_left_top, y_right_top, wall_color, fill_color
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swcr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // fields from bit 0: kind
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fields from bit 0: span_column, span_start, span_end, span_color
    output logic [swcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // last_span
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import swcr_pkg::*;

    localparam int ONE   = 1 << FRAC_BITS;
    localparam int CW    = FRAC_BITS + 8;
    localparam int XW    = ((CW + 1 > 24) ? CW + 1 : 24) + 1;
    localparam int TW    = XW + 1;
    localparam int PW    = 25 + TW;
    localparam int QW    = ((CW > 24) ? CW : 24) + 1;
    localparam int YW    = QW + 2;
    localparam int DEPTH = SECTORS * COLUMNS;
    localparam int MAW   = $clog2(DEPTH);

    // stage indexes
    localparam int ST_D0 = 4;
    localparam int ST_SA = ST_D0 + QW + 1;
    localparam int ST_SB = ST_SA + 1;
    localparam int ST_SC = ST_SB + 1;
    localparam int NS    = ST_SC + 1;

    typedef struct packed {
        logic [2:0]         kind;
        logic               live;
        logic               in_store;
        logic [MAW-1:0]     addr;
        logic [7:0]         column;
        logic [31:0]        wall_color;
        logic [31:0]        fill_color;
        logic signed [23:0] ylb;
        logic signed [23:0] ylt;
    } meta_t;

    // configuration registers
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [8:0] w_sat;
    logic [8:0] h_sat;
    logic [7:0] wm1;
    logic [7:0] hm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {23'd0, height_reg} : {23'd0, width_reg};
    assign w_sat  = sat_dim(width_reg);
    assign h_sat  = sat_dim(height_reg);
    assign wm1    = 8'(w_sat - 9'd1);
    assign hm1    = 8'(h_sat - 9'd1);

    // clearing pass over the line store
    logic           clearing_reg;
    logic [MAW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + MAW'(1);
            if (clr_cnt_reg == MAW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage valids and load enables, bubbles collapse under a stall
    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;
    logic          en_o;
    logic          accept;

    always_comb
    begin
        en[NS] = en_o;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0] && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= accept;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: input register
    logic [2:0]         s0_kind;
    logic [1:0]         s0_sector;
    logic [7:0]         s0_column;
    logic signed [23:0] s0_xl;
    logic signed [23:0] s0_xr;
    logic signed [23:0] s0_ylb;
    logic signed [23:0] s0_yrb;
    logic signed [23:0] s0_ylt;
    logic signed [23:0] s0_yrt;
    logic [31:0]        s0_wall;
    logic [31:0]        s0_fill;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_kind   <= s_tuser;
            s0_sector <= s_tdata[1:0];
            s0_column <= s_tdata[9:2];
            s0_xl     <= s_tdata[33:10];
            s0_xr     <= s_tdata[57:34];
            s0_ylb    <= s_tdata[81:58];
            s0_yrb    <= s_tdata[105:82];
            s0_ylt    <= s_tdata[129:106];
            s0_yrt    <= s_tdata[153:130];
            s0_wall   <= s_tdata[185:154];
            s0_fill   <= s_tdata[217:186];
        end
    end

    // stage 1 logic: clamp x ends, live test, deltas and column offset
    logic signed [XW-1:0] xl_x;
    logic signed [XW-1:0] xr_x;
    logic signed [XW-1:0] xhi;
    logic signed [XW-1:0] xlc;
    logic signed [XW-1:0] xrc;
    logic signed [XW-1:0] colone;
    logic signed [XW-1:0] xdiff;
    logic signed [24:0]   dx;
    logic [1:0]           sec_m;
    meta_t                s1_meta;

    always_comb
    begin
        xl_x   = XW'(s0_xl);
        xr_x   = XW'(s0_xr);
        xhi    = signed'(XW'(wm1) << FRAC_BITS);
        colone = signed'(XW'(s0_column) << FRAC_BITS);
        xlc    = (xl_x < XW'(ONE)) ? XW'(ONE) : ((xl_x > xhi) ? xhi : xl_x);
        xrc    = (xr_x < XW'(ONE)) ? XW'(ONE) : ((xr_x > xhi) ? xhi : xr_x);
        xdiff  = colone - xl_x;
        dx     = 25'(s0_xr) - 25'(s0_xl);
        sec_m  = s0_sector;
        for (int i = 0; i < 3; i++)
        begin
            if (32'(sec_m) >= SECTORS)
            begin
                sec_m = sec_m - 2'(SECTORS);
            end
        end
        s1_meta.kind       = s0_kind;
        s1_meta.live       = (s0_column >= 8'(xlc >>> FRAC_BITS)) && (colone < xrc);
        s1_meta.in_store   = 32'(s0_column) < COLUMNS;
        s1_meta.addr       = MAW'(32'(sec_m) * COLUMNS
                             + (s1_meta.in_store ? 32'(s0_column) : 32'd0));
        s1_meta.column     = s0_column;
        s1_meta.wall_color = s0_wall;
        s1_meta.fill_color = s0_fill;
        s1_meta.ylb        = s0_ylb;
        s1_meta.ylt        = s0_ylt;
    end

    // item description travelling beside the arithmetic
    meta_t meta_reg [1:NS-1];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            meta_reg[1] <= s1_meta;
        end
        for (int k = 2; k < NS; k++)
        begin
            if (en[k])
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // stage 1 registers
    logic signed [24:0]   s1_dx;
    logic signed [TW-1:0] s1_t;
    logic signed [24:0]   s1_dyb;
    logic signed [24:0]   s1_dyt;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_dx  <= (dx == 25'sd0) ? 25'(ONE) : dx;
            s1_t   <= (TW'(xdiff) <<< 1) + TW'(ONE);
            s1_dyb <= 25'(s0_yrb) - 25'(s0_ylb);
            s1_dyt <= 25'(s0_yrt) - 25'(s0_ylt);
        end
    end

    // stage 2: products and doubled divisor
    logic signed [PW-1:0] s2_pb;
    logic signed [PW-1:0] s2_pt;
    logic signed [25:0]   s2_d;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_pb <= PW'(s1_dyb) * PW'(s1_t);
            s2_pt <= PW'(s1_dyt) * PW'(s1_t);
            s2_d  <= {s1_dx, 1'b0};
        end
    end

    // stage 3: magnitudes and quotient signs
    logic [PW-1:0] s3_pbm;
    logic [PW-1:0] s3_ptm;
    logic [25:0]   s3_dm;
    logic          s3_nb;
    logic          s3_nt;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_pbm <= s2_pb[PW-1] ? PW'(-s2_pb) : PW'(s2_pb);
            s3_ptm <= s2_pt[PW-1] ? PW'(-s2_pt) : PW'(s2_pt);
            s3_dm  <= s2_d[25] ? 26'(-s2_d) : 26'(s2_d);
            s3_nb  <= s2_pb[PW-1] ^ s2_d[25];
            s3_nt  <= s2_pt[PW-1] ^ s2_d[25];
        end
    end

    // divider lanes for the bottom and top edges
    logic [QW-1:0] qb;
    logic [QW-1:0] qt;
    logic          ovb;
    logic          ovt;
    logic          negb;
    logic          negt;

    swcr_div #(
        .PMW (PW),
        .AW  (26),
        .QW  (QW)
    ) u_div_bottom (
        .clk     (clk),
        .en      (en[ST_D0 +: QW+1]),
        .num     (s3_pbm),
        .den     (s3_dm),
        .neg     (s3_nb),
        .quot    (qb),
        .ovf     (ovb),
        .neg_out (negb)
    );

    swcr_div #(
        .PMW (PW),
        .AW  (26),
        .QW  (QW)
    ) u_div_top (
        .clk     (clk),
        .en      (en[ST_D0 +: QW+1]),
        .num     (s3_ptm),
        .den     (s3_dm),
        .neg     (s3_nt),
        .quot    (qt),
        .ovf     (ovt),
        .neg_out (negt)
    );

    // stage a: signed quotient added to the left end
    logic signed [YW-1:0] qbm;
    logic signed [YW-1:0] qtm;
    logic signed [YW-1:0] sa_yb;
    logic signed [YW-1:0] sa_yt;

    assign qbm = ovb ? (YW'(1) <<< QW) : YW'(qb);
    assign qtm = ovt ? (YW'(1) <<< QW) : YW'(qt);

    always_ff @(posedge clk)
    begin
        if (en[ST_SA])
        begin
            sa_yb <= YW'(meta_reg[ST_SA-1].ylb) + (negb ? -qbm : qbm);
            sa_yt <= YW'(meta_reg[ST_SA-1].ylt) + (negt ? -qtm : qtm);
        end
    end

    // stage b: clamp edges to the screen height
    logic signed [YW-1:0] yhi;
    logic [CW-1:0]        sb_yb;
    logic [CW-1:0]        sb_yt;

    assign yhi = signed'(YW'(hm1) << FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en[ST_SB])
        begin
            sb_yb <= (sa_yb < YW'(ONE)) ? CW'(ONE) : ((sa_yb > yhi) ? CW'(yhi) : CW'(sa_yb));
            sb_yt <= (sa_yt < YW'(ONE)) ? CW'(ONE) : ((sa_yt > yhi) ? CW'(yhi) : CW'(sa_yt));
        end
    end

    // line store read as an item enters stage c, write as it leaves
    logic [7:0]     ram_rdata;
    logic [7:0]     fwd_data_reg;
    logic           fwd_hit_reg;
    logic [CW-1:0]  sc_yb;
    logic [CW-1:0]  sc_yt;
    logic           wr_fire;
    logic [7:0]     wr_data;
    logic [7:0]     line;
    meta_t          sc_meta;

    assign sc_meta = meta_reg[ST_SC];
    assign wr_fire = vld_reg[ST_SC] && en_o && sc_meta.live && sc_meta.in_store
                     && ((sc_meta.kind == KIND_STORE_BOTTOM)
                         || (sc_meta.kind == KIND_STORE_TOP));
    assign wr_data = (sc_meta.kind == KIND_STORE_BOTTOM) ? sc_yb[FRAC_BITS +: 8]
                                                         : sc_yt[FRAC_BITS +: 8];

    swcr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (clearing_reg || wr_fire),
        .waddr (clearing_reg ? clr_cnt_reg : sc_meta.addr),
        .wdata (clearing_reg ? 8'd0 : wr_data),
        .re    (en[ST_SC]),
        .raddr (meta_reg[ST_SB].addr),
        .rdata (ram_rdata)
    );

    // forward a write that passes the read of the next item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (en[ST_SC])
        begin
            fwd_hit_reg <= wr_fire && (sc_meta.addr == meta_reg[ST_SB].addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SC])
        begin
            fwd_data_reg <= wr_data;
            sc_yb        <= sb_yb;
            sc_yt        <= sb_yt;
        end
    end

    assign line = !sc_meta.in_store ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : ram_rdata);

    // spans of the item in stage c
    span_t slot_a;
    span_t slot_b;

    swcr_span #(
        .FRAC_BITS (FRAC_BITS)
    ) u_span (
        .kind       (sc_meta.kind),
        .live       (sc_meta.live),
        .line       (line),
        .yb         (sc_yb),
        .yt         (sc_yt),
        .column     (sc_meta.column),
        .wall_color (sc_meta.wall_color),
        .fill_color (sc_meta.fill_color),
        .slot_a     (slot_a),
        .slot_b     (slot_b)
    );

    // output register holding up to two spans
    logic  pend_a_reg;
    logic  pend_b_reg;
    span_t out_a_reg;
    span_t out_b_reg;
    span_t out_sel;

    assign en_o = !(pend_a_reg || pend_b_reg) || (m_tready && !(pend_a_reg && pend_b_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
        end
        else if (en_o)
        begin
            pend_a_reg <= vld_reg[ST_SC] && slot_a.valid;
            pend_b_reg <= vld_reg[ST_SC] && slot_b.valid;
        end
        else if (m_tready)
        begin
            pend_a_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            out_a_reg <= slot_a;
            out_b_reg <= slot_b;
        end
    end

    // master side transaction
    assign out_sel  = pend_a_reg ? out_a_reg : out_b_reg;
    assign m_tvalid = pend_a_reg || pend_b_reg;
    assign m_tlast  = pend_a_reg ? !pend_b_reg : 1'b1;
    assign m_tdata  = {out_sel.color, out_sel.stop, out_sel.start, out_sel.column};

endmodule

// ===== tb/sector_wall_column_raster_test.sv =====
// testbench for sector_wall_column_raster: directed and random wall columns
// checked span by span against a behavioral predictor; depends on swcr_pkg
`timescale 1ns / 1ps

module sector_wall_column_raster_test;
    import swcr_pkg::*;

    localparam int LATENCY_WAIT = 80;
    localparam int STALL_LIMIT  = 6000;
    localparam longint ONE      = 256;

    typedef struct {
        logic [2:0]         kind;
        logic [1:0]         sector;
        logic [7:0]         column;
        logic signed [23:0] xl;
        logic signed [23:0] xr;
        logic signed [23:0] ylb;
        logic signed [23:0] yrb;
        logic signed [23:0] ylt;
        logic signed [23:0] yrt;
        logic [31:0]        wall_color;
        logic [31:0]        fill_color;
    } wall_col_t;

    typedef struct {
        logic [7:0]  column;
        logic [7:0]  start;
        logic [7:0]  stop;
        logic [31:0] color;
        logic        last;
    } span_exp_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [2:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    span_exp_t   span_queue[$];
    logic [7:0]  line_mem[0:1023];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    int          tx_idle;
    int          rx_idle;
    int          fail_count;
    int          stall_count;

    sector_wall_column_raster dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // span checker
    always @(posedge clk)
    begin
        span_exp_t ex;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (span_queue.size() == 0)
            begin
                $error("unexpected span transaction %h", m_tdata);
                fail_count++;
            end
            else
            begin
                ex = span_queue.pop_front();
                if (m_tdata[7:0] !== ex.column)
                begin
                    $error("span_column exp %0d got %0d", ex.column, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== ex.start)
                begin
                    $error("span_start exp %0d got %0d", ex.start, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[23:16] !== ex.stop)
                begin
                    $error("span_end exp %0d got %0d", ex.stop, m_tdata[23:16]);
                    fail_count++;
                end
                if (m_tdata[55:24] !== ex.color)
                begin
                    $error("span_color exp %h got %h", ex.color, m_tdata[55:24]);
                    fail_count++;
                end
                if (m_tlast !== ex.last)
                begin
                    $error("last_span exp %0d got %0d", ex.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            v = lo;
        end
        if (v > hi)
        begin
            v = hi;
        end
        return v;
    endfunction

    function automatic longint dim_used(logic [8:0] v);
        if (v < 2)
        begin
            return 2;
        end
        if (v > 256)
        begin
            return 256;
        end
        return longint'(v);
    endfunction

    // spans caused by one column; updates the line store copy
    function automatic void predict_spans(wall_col_t c);
        longint    w, h, col, dx, t, yb, yt, line, s, e, xlc, xrc;
        int        addr;
        span_exp_t sp[2];
        int        n;
        n    = 0;
        w    = dim_used(width_reg);
        h    = dim_used(height_reg);
        col  = longint'(c.column);
        addr = int'(c.sector) * 256 + int'(c.column);
        xlc  = clamp(c.xl, ONE, (w - 1) * ONE);
        xrc  = clamp(c.xr, ONE, (w - 1) * ONE);
        if (col < (xlc >>> 8) || col * ONE >= xrc)
        begin
            return;
        end
        dx = longint'(c.xr) - longint'(c.xl);
        if (dx == 0)
        begin
            dx = ONE;
        end
        t  = 2 * (col * ONE - longint'(c.xl)) + ONE;
        yb = c.ylb + ((longint'(c.yrb) - longint'(c.ylb)) * t) / (2 * dx);
        yt = c.ylt + ((longint'(c.yrt) - longint'(c.ylt)) * t) / (2 * dx);
        yb = clamp(yb, ONE, (h - 1) * ONE);
        yt = clamp(yt, ONE, (h - 1) * ONE);
        line = longint'(line_mem[addr]);
        if (c.kind == KIND_STORE_BOTTOM)
        begin
            line_mem[addr] = 8'(yb >>> 8);
        end
        if (c.kind == KIND_STORE_TOP)
        begin
            line_mem[addr] = 8'(yt >>> 8);
        end
        if (c.kind == KIND_FILL_BOTTOM)
        begin
            s = line;
            e = (yb + ONE - 1) >>> 8;
            if (e > s)
            begin
                sp[n] = '{c.column, 8'(s), 8'(e), c.fill_color, 1'b0};
                n++;
            end
        end
        if (c.kind == KIND_FILL_TOP)
        begin
            s = yt >>> 8;
            e = line;
            if (e > s)
            begin
                sp[n] = '{c.column, 8'(s), 8'(e), c.fill_color, 1'b0};
                n++;
            end
        end
        s = yb >>> 8;
        e = (yt + ONE - 1) >>> 8;
        if (e > s)
        begin
            sp[n] = '{c.column, 8'(s), 8'(e), c.wall_color, 1'b0};
            n++;
        end
        if (n > 0)
        begin
            sp[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            span_queue.push_back(sp[i]);
        end
    endfunction

    // present one column, with optional leading gap, until accepted
    task automatic send_column(wall_col_t c);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.kind;
        s_tdata  <= {6'b0, c.fill_color, c.wall_color, c.yrt, c.ylt, c.yrb, c.ylb,
                     c.xr, c.xl, c.column, c.sector};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_spans(c);
    endtask

    // stop sending and wait until all spans are out and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (span_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dims(logic [8:0] w, logic [8:0] h);
        drain();
        apb_write({REG_WIDTH, 2'b00}, {23'b0, w});
        width_reg = w;
        apb_write({REG_HEIGHT, 2'b00}, {23'b0, h});
        height_reg = h;
    endtask

    function automatic wall_col_t make_col(logic [2:0] k, logic [1:0] sec, logic [7:0] col,
                                           int xl, int xr, int ylb, int yrb, int ylt, int yrt);
        wall_col_t c;
        c = '{k, sec, col, 24'(xl), 24'(xr), 24'(ylb), 24'(yrb), 24'(ylt), 24'(yrt),
              $urandom, $urandom};
        return c;
    endfunction

    // random column; well-formed ones keep the column on screen, noise uses full ranges
    function automatic wall_col_t random_col(bit wellformed);
        wall_col_t c;
        int        w, h;
        w = int'(dim_used(width_reg));
        h = int'(dim_used(height_reg));
        c.kind       = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                 : 3'($urandom_range(4));
        c.sector     = 2'($urandom);
        c.wall_color = $urandom;
        c.fill_color = $urandom;
        if (wellformed)
        begin
            c.column = 8'($urandom_range(w - 1));
            c.xl  = 24'($urandom_range(int'(c.column) * 256 + 255) - 64);
            c.xr  = 24'(int'(c.column) * 256 + 1 + $urandom_range(w * 256));
            c.ylb = 24'($urandom_range(h * 128) - 200);
            c.yrb = 24'($urandom_range(h * 128) - 200);
            c.ylt = 24'($urandom_range(h * 256, h * 64));
            c.yrt = 24'($urandom_range(h * 256 + 300, h * 64));
        end
        else
        begin
            c.column = 8'($urandom);
            c.xl  = 24'($urandom);
            c.xr  = 24'($urandom);
            c.ylb = 24'($urandom);
            c.yrb = 24'($urandom);
            c.ylt = 24'($urandom);
            c.yrt = 24'($urandom);
        end
        return c;
    endfunction

    // directed: field extremes, every kind, off-span and empty columns
    task automatic test_directed();
        wall_col_t c;
        for (int k = 0; k < 8; k++)
        begin
            send_column(make_col(3'(k), 2'(k), 8'(10 + k), 2560, 20480, 512, 6400,
                                 20000, 28000));
        end
        // store then fill the same line
        send_column(make_col(KIND_STORE_BOTTOM, 2'd3, 8'd40, 0, 40000, 9000, 9000, 20000, 20000));
        send_column(make_col(KIND_FILL_BOTTOM, 2'd3, 8'd40, 0, 40000, 2000, 2000, 20000, 20000));
        send_column(make_col(KIND_STORE_TOP, 2'd2, 8'd41, 0, 40000, 900, 900, 25000, 25000));
        send_column(make_col(KIND_FILL_TOP, 2'd2, 8'd41, 0, 40000, 900, 900, 5000, 5000));
        // zero dx and extreme coordinates
        send_column(make_col(KIND_NONE, 2'd0, 8'd5, 1280, 1280, 256, 9000, 300, 20000));
        send_column(make_col(KIND_NONE, 2'd1, 8'd0, -8388608, 8388607, -8388608, 8388607,
                             8388607, -8388608));
        send_column(make_col(KIND_FILL_TOP, 2'd1, 8'd255, -8388608, 8388607, 8388607,
                             -8388608, -8388608, 8388607));
        // columns at the edges of the clamped span
        send_column(make_col(KIND_STORE_BOTTOM, 2'd0, 8'd159, 0, 8388607, 512, 512, 900, 900));
        send_column(make_col(KIND_STORE_BOTTOM, 2'd0, 8'd160, 0, 8388607, 512, 512, 900, 900));
        send_column(make_col(KIND_NONE, 2'd0, 8'd1, 0, 8388607, 512, 512, 900, 900));
        // inverted edges: no wall span, the fill column gives only its fill span
        send_column(make_col(KIND_NONE, 2'd0, 8'd30, 0, 40000, 20000, 20000, 512, 512));
        c = make_col(KIND_FILL_BOTTOM, 2'd0, 8'd30, 0, 40000, 20000, 20000, 512, 512);
        c.wall_color = '1;
        c.fill_color = '0;
        send_column(c);
    endtask

    // dimension registers at and beyond their limits
    task automatic test_dims();
        logic [8:0] dims[6][2] = '{'{9'd0, 9'd1}, '{9'd511, 9'd511}, '{9'd256, 9'd2},
                                   '{9'd2, 9'd256}, '{9'd257, 9'd3}, '{9'd37, 9'd200}};
        for (int d = 0; d < 6; d++)
        begin
            set_dims(dims[d][0], dims[d][1]);
            repeat (12) send_column(random_col($urandom_range(3) != 0));
        end
    endtask

    // random phase: store/fill pairs, single columns and noise
    task automatic test_random(int count);
        wall_col_t c;
        int        sent;
        sent = 0;
        while (sent < count)
        begin
            c = random_col($urandom_range(9) != 0);
            send_column(c);
            sent++;
            if (c.kind == KIND_STORE_BOTTOM || c.kind == KIND_STORE_TOP)
            begin
                c.kind = (c.kind == KIND_STORE_BOTTOM) ? KIND_FILL_BOTTOM : KIND_FILL_TOP;
                c.ylb = 24'($urandom_range(6000));
                c.yrt = 24'($urandom_range(40000, 1000));
                send_column(c);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= KIND_NONE;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        m_tready   <= 1'b0;
        stall_count <= 0;
        fail_count = 0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        tx_idle    = 34;
        rx_idle    = 80;
        for (int i = 0; i < 1024; i++)
        begin
            line_mem[i] = 8'd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_dims();
        set_dims(9'd160, 9'd120);
        test_random(200);
        tx_idle = 80;
        rx_idle = 34;
        set_dims(9'd256, 9'd256);
        test_random(200);
        // hold off until every span has arrived
        drain();
        tx_idle = 0;
        rx_idle = 0;
        set_dims(9'd64, 9'd48);
        test_random(200);
        drain();

        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swcr_pkg.sv
rtl/swcr_ram.sv
rtl/swcr_div.sv
rtl/swcr_span.sv
rtl/sector_wall_column_raster.sv
tb/sector_wall_column_raster_test.sv
